>>> design/ats_pkg.sv
`default_nettype none
package ats_pkg;

  localparam int unsigned MaxRes = 4;
  localparam logic [62:0] SatMax = {63{1'b1}};

  typedef enum logic [3:0] {
    TK_TEXT    = 4'd0,
    TK_IDENT   = 4'd1,
    TK_DOTID   = 4'd2,
    TK_INT     = 4'd3,
    TK_STRING  = 4'd4,
    TK_NEWLINE = 4'd5,
    TK_HASH    = 4'd6,
    TK_COMMA   = 4'd7,
    TK_COLON   = 4'd8,
    TK_LPAREN  = 4'd9,
    TK_RPAREN  = 4'd10,
    TK_MINUS   = 4'd11,
    TK_PLUS    = 4'd12,
    TK_EOF     = 4'd13
  } tok_kind_e;

  typedef enum logic [3:0] {
    SM_IDLE    = 4'd0,
    SM_COMMENT = 4'd1,
    SM_STR     = 4'd2,
    SM_ESC     = 4'd3,
    SM_OCT     = 4'd4,
    SM_IDENT   = 4'd5,
    SM_DOTID   = 4'd6,
    SM_DOT     = 4'd7,
    SM_NUM     = 4'd8,
    SM_HEXX    = 4'd9,
    SM_SUFFIX  = 4'd10
  } scan_mode_e;

  typedef struct packed {
    logic [31:0] line;
    logic [62:0] value;
    tok_kind_e   kind;
  } res_t;

  typedef struct packed {
    res_t [MaxRes-1:0] r;
    logic [2:0]        n;
  } bundle_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == 8'h5f);
  endfunction

  // {valid, digit value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (is_digit(c)) begin
      t = c - 8'h30;
      return {1'b1, t[3:0]};
    end
    if ((c >= 8'h61) && (c <= 8'h66)) begin
      t = c - 8'h57;
      return {1'b1, t[3:0]};
    end
    if ((c >= 8'h41) && (c <= 8'h46)) begin
      t = c - 8'h37;
      return {1'b1, t[3:0]};
    end
    return 5'd0;
  endfunction

  // acc * base + d, clamped at the largest 63-bit value
  function automatic logic [62:0] sat_acc(input logic [62:0] acc, input logic hex,
                                          input logic [3:0] d);
    logic [67:0] t;
    t = 68'd0;
    if (hex) begin
      t = {1'b0, acc, 4'b0} + {64'd0, d};
    end else begin
      t = {2'b0, acc, 3'b0} + {4'b0, acc, 1'b0} + {64'd0, d};
    end
    if (t > {5'd0, SatMax}) begin
      return SatMax;
    end
    return t[62:0];
  endfunction

  function automatic bundle_t push(input bundle_t b, input tok_kind_e k,
                                   input logic [62:0] v, input logic [31:0] line);
    bundle_t o;
    o = b;
    if (b.n < 3'd4) begin
      o.r[b.n[1:0]].kind  = k;
      o.r[b.n[1:0]].value = v;
      o.r[b.n[1:0]].line  = line;
      o.n = b.n + 3'd1;
    end
    return o;
  endfunction

endpackage
`default_nettype wire

>>> design/assembler_token_scanner_top.sv
`default_nettype none
// Channel  | Dir | Beat contents
// s_axis   | in  | tdata[7:0] source_byte; tuser[0] end_of_input
// m_axis   | out | tdata[3:0] token_kind, [66:4] token_value, [98:67] line_number;
//          |     | tlast = last result of the source beat
// A source beat lands in an input register and is scanned into a bundle of up to four
// results. While m_axis is ready, the bundle drains one result per cycle and a beat is
// taken every cycle if each beat yields at most one result; a beat with more results
// holds the scanner until the single output port has drained them. Reset (rst_ni low,
// asynchronous) clears the scanner to between tokens, line one, and empties both
// registers. A stall on m_axis holds the bundle and the next beat in the input register.
module assembler_token_scanner_top (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  wire logic [7:0]    s_axis_tdata_i,   // source_byte
  input  wire logic [0:0]    s_axis_tuser_i,   // end_of_input
  output logic               m_axis_tvalid_o,
  input  wire logic          m_axis_tready_i,
  output logic [103:0]       m_axis_tdata_o,   // token_kind, token_value, line_number
  output logic               m_axis_tlast_o    // last_of_item
);
  import ats_pkg::*;

  logic       in_v_q;
  logic [7:0] in_byte_q;
  logic       in_eoi_q;
  logic       fire;
  logic       free;
  bundle_t    bnd;
  res_t       res;

  // advance the held beat into the scanner when the bundle empties
  assign fire            = in_v_q && free;
  assign s_axis_tready_o = !in_v_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_v_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_eoi_q  <= s_axis_tuser_i[0];
    end
  end

  ats_scan_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .byte_i   (in_byte_q),
    .eoi_i    (in_eoi_q),
    .bundle_o (bnd)
  );

  ats_result_buf u_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (fire),
    .bundle_i (bnd),
    .free_o   (free),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .res_o    (res),
    .last_o   (m_axis_tlast_o)
  );

  // pad the 99-bit result to whole bytes
  assign m_axis_tdata_o = {5'd0, res.line, res.value, res.kind};

endmodule
`default_nettype wire

>>> design/ats_scan_core.sv
`default_nettype none
module ats_scan_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            fire_i,
  input  wire logic [7:0]      byte_i,
  input  wire logic            eoi_i,
  output ats_pkg::bundle_t     bundle_o
);
  import ats_pkg::*;

  scan_mode_e  mode_q, mode_d;
  logic [62:0] acc_q, acc_d;
  logic [31:0] len_q, len_d;
  logic [8:0]  oct_q, oct_d;
  logic [1:0]  octn_q, octn_d;
  logic [7:0]  pend_q, pend_d;
  logic        hex_q, hex_d;
  logic [31:0] line_q, line_d;

  bundle_t     bnd;
  logic [7:0]  c;
  logic [7:0]  ec;
  logic [4:0]  hv;
  logic        go_str, go_id, go_idle;

  always_comb begin
    mode_d  = mode_q;
    acc_d   = acc_q;
    len_d   = len_q;
    oct_d   = oct_q;
    octn_d  = octn_q;
    pend_d  = pend_q;
    hex_d   = hex_q;
    line_d  = line_q;
    bnd     = '0;
    c       = byte_i;
    ec      = byte_i;
    hv      = hex_val(byte_i);
    go_str  = 1'b0;
    go_id   = 1'b0;
    go_idle = 1'b0;
    if (eoi_i) begin
      // close any open token, then eof
      unique case (mode_q)
        SM_STR, SM_ESC: bnd = push(bnd, TK_STRING, {31'd0, len_d}, line_d);
        SM_OCT: begin
          bnd = push(bnd, TK_TEXT, {55'd0, oct_d[7:0]}, line_d);
          len_d = len_d + 32'd1;
          bnd = push(bnd, TK_STRING, {31'd0, len_d}, line_d);
        end
        SM_IDENT: bnd = push(bnd, TK_IDENT, {31'd0, len_d}, line_d);
        SM_DOTID: bnd = push(bnd, TK_DOTID, {31'd0, len_d}, line_d);
        SM_DOT:   bnd = push(bnd, TK_DOTID, 63'd1, line_d);
        SM_NUM:   bnd = push(bnd, TK_INT, acc_d, line_d);
        SM_HEXX: begin
          bnd = push(bnd, TK_INT, acc_d, line_d);
          bnd = push(bnd, TK_TEXT, {55'd0, pend_d}, line_d);
          len_d = 32'd1;
          bnd = push(bnd, TK_IDENT, {31'd0, len_d}, line_d);
        end
        SM_SUFFIX: begin
          bnd = push(bnd, TK_TEXT, {55'd0, pend_d}, line_d);
          len_d = len_d + 32'd1;
          bnd = push(bnd, TK_IDENT, {31'd0, len_d}, line_d);
        end
        default: ;
      endcase
      bnd    = push(bnd, TK_EOF, 63'd0, line_d);
      mode_d = SM_IDLE;
      hex_d  = 1'b0;
      oct_d  = 9'd0;
      octn_d = 2'd0;
    end else begin
      unique case (mode_q)
        SM_COMMENT: begin
          if (c == 8'h0a) begin
            mode_d  = SM_IDLE;
            go_idle = 1'b1;
          end
        end
        SM_STR: go_str = 1'b1;
        SM_ESC: begin
          if ((c >= 8'h30) && (c <= 8'h37)) begin
            oct_d  = {6'd0, c[2:0]};
            octn_d = 2'd1;
            mode_d = SM_OCT;
          end else begin
            if (c == 8'h6e) begin
              ec = 8'h0a;
            end else if (c == 8'h74) begin
              ec = 8'h09;
            end else if (c == 8'h72) begin
              ec = 8'h0d;
            end
            bnd    = push(bnd, TK_TEXT, {55'd0, ec}, line_d);
            len_d  = len_d + 32'd1;
            mode_d = SM_STR;
          end
        end
        SM_OCT: begin
          if ((c >= 8'h30) && (c <= 8'h37) && (octn_q != 2'd3)) begin
            oct_d  = {oct_q[5:0], c[2:0]};
            octn_d = octn_q + 2'd1;
            if (octn_d == 2'd3) begin
              bnd    = push(bnd, TK_TEXT, {55'd0, oct_d[7:0]}, line_d);
              len_d  = len_d + 32'd1;
              oct_d  = 9'd0;
              octn_d = 2'd0;
              mode_d = SM_STR;
            end
          end else begin
            bnd    = push(bnd, TK_TEXT, {55'd0, oct_q[7:0]}, line_d);
            len_d  = len_d + 32'd1;
            oct_d  = 9'd0;
            octn_d = 2'd0;
            mode_d = SM_STR;
            go_str = 1'b1;
          end
        end
        SM_IDENT, SM_DOTID: go_id = 1'b1;
        SM_DOT: begin
          if (is_word(c)) begin
            bnd    = push(bnd, TK_TEXT, {55'd0, c}, line_d);
            len_d  = len_d + 32'd1;
            mode_d = SM_DOTID;
          end else begin
            bnd     = push(bnd, TK_DOTID, 63'd1, line_d);
            mode_d  = SM_IDLE;
            go_idle = 1'b1;
          end
        end
        SM_NUM: begin
          if (hex_q) begin
            if (hv[4]) begin
              acc_d = sat_acc(acc_q, 1'b1, hv[3:0]);
              bnd   = push(bnd, TK_TEXT, {55'd0, c}, line_d);
              len_d = len_d + 32'd1;
            end else begin
              bnd     = push(bnd, TK_INT, acc_q, line_d);
              hex_d   = 1'b0;
              mode_d  = SM_IDLE;
              go_idle = 1'b1;
            end
          end else if (is_digit(c)) begin
            acc_d = sat_acc(acc_q, 1'b0, c[3:0]);
            bnd   = push(bnd, TK_TEXT, {55'd0, c}, line_d);
            len_d = len_d + 32'd1;
          end else if (((c == 8'h78) || (c == 8'h58)) && (len_q == 32'd1) &&
                       (acc_q == 63'd0)) begin
            pend_d = c;
            mode_d = SM_HEXX;
          end else if ((c == 8'h62) || (c == 8'h66)) begin
            pend_d = c;
            mode_d = SM_SUFFIX;
          end else begin
            bnd     = push(bnd, TK_INT, acc_q, line_d);
            hex_d   = 1'b0;
            mode_d  = SM_IDLE;
            go_idle = 1'b1;
          end
        end
        SM_HEXX: begin
          if (hv[4]) begin
            bnd    = push(bnd, TK_TEXT, {55'd0, pend_q}, line_d);
            bnd    = push(bnd, TK_TEXT, {55'd0, c}, line_d);
            len_d  = len_d + 32'd2;
            acc_d  = {59'd0, hv[3:0]};
            hex_d  = 1'b1;
            mode_d = SM_NUM;
          end else begin
            bnd    = push(bnd, TK_INT, acc_q, line_d);
            hex_d  = 1'b0;
            bnd    = push(bnd, TK_TEXT, {55'd0, pend_q}, line_d);
            len_d  = 32'd1;
            mode_d = SM_IDENT;
            go_id  = 1'b1;
          end
        end
        SM_SUFFIX: begin
          if (is_word(c)) begin
            bnd   = push(bnd, TK_INT, acc_q, line_d);
            hex_d = 1'b0;
            len_d = 32'd0;
          end
          bnd    = push(bnd, TK_TEXT, {55'd0, pend_q}, line_d);
          len_d  = len_d + 32'd1;
          mode_d = SM_IDENT;
          go_id  = 1'b1;
        end
        default: begin
          mode_d  = SM_IDLE;
          go_idle = 1'b1;
        end
      endcase

      // string byte after an octal escape or in plain string mode
      if (go_str) begin
        if (c == 8'h22) begin
          bnd    = push(bnd, TK_STRING, {31'd0, len_d}, line_d);
          mode_d = SM_IDLE;
        end else if (c == 8'h5c) begin
          mode_d = SM_ESC;
        end else begin
          bnd   = push(bnd, TK_TEXT, {55'd0, c}, line_d);
          len_d = len_d + 32'd1;
        end
      end

      // identifier continuation or close
      if (go_id) begin
        if (is_word(c) || (c == 8'h2e)) begin
          bnd   = push(bnd, TK_TEXT, {55'd0, c}, line_d);
          len_d = len_d + 32'd1;
        end else begin
          bnd = push(bnd, (mode_d == SM_DOTID) ? TK_DOTID : TK_IDENT,
                     {31'd0, len_d}, line_d);
          mode_d  = SM_IDLE;
          go_idle = 1'b1;
        end
      end

      // byte seen between tokens
      if (go_idle) begin
        case (c)
          8'h0a: begin
            bnd    = push(bnd, TK_NEWLINE, 63'd0, line_d);
            line_d = line_d + 32'd1;
          end
          8'h7c: mode_d = SM_COMMENT;
          8'h22: begin
            len_d  = 32'd0;
            mode_d = SM_STR;
          end
          8'h2e: begin
            bnd    = push(bnd, TK_TEXT, {55'd0, c}, line_d);
            len_d  = 32'd1;
            mode_d = SM_DOT;
          end
          8'h25: begin
            len_d  = 32'd0;
            mode_d = SM_IDENT;
          end
          8'h23: bnd = push(bnd, TK_HASH, 63'd0, line_d);
          8'h2c: bnd = push(bnd, TK_COMMA, 63'd0, line_d);
          8'h3a: bnd = push(bnd, TK_COLON, 63'd0, line_d);
          8'h28: bnd = push(bnd, TK_LPAREN, 63'd0, line_d);
          8'h29: bnd = push(bnd, TK_RPAREN, 63'd0, line_d);
          8'h2d: bnd = push(bnd, TK_MINUS, 63'd0, line_d);
          8'h2b: bnd = push(bnd, TK_PLUS, 63'd0, line_d);
          default: begin
            if (is_digit(c)) begin
              bnd    = push(bnd, TK_TEXT, {55'd0, c}, line_d);
              len_d  = 32'd1;
              acc_d  = {59'd0, c[3:0]};
              hex_d  = 1'b0;
              mode_d = SM_NUM;
            end else if (is_alpha(c) || (c == 8'h5f)) begin
              bnd    = push(bnd, TK_TEXT, {55'd0, c}, line_d);
              len_d  = 32'd1;
              mode_d = SM_IDENT;
            end
          end
        endcase
      end
    end
  end

  assign bundle_o = bnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= SM_IDLE;
      acc_q  <= 63'd0;
      len_q  <= 32'd0;
      oct_q  <= 9'd0;
      octn_q <= 2'd0;
      pend_q <= 8'd0;
      hex_q  <= 1'b0;
      line_q <= 32'd1;
    end else if (fire_i) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      len_q  <= len_d;
      oct_q  <= oct_d;
      octn_q <= octn_d;
      pend_q <= pend_d;
      hex_q  <= hex_d;
      line_q <= line_d;
    end
  end

endmodule
`default_nettype wire

>>> design/ats_result_buf.sv
`default_nettype none
module ats_result_buf (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire ats_pkg::bundle_t bundle_i,
  output logic                  free_o,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output ats_pkg::res_t         res_o,
  output logic                  last_o
);
  import ats_pkg::*;

  res_t [MaxRes-1:0] r_q;
  logic [2:0]        cnt_q, cnt_d;
  logic [1:0]        idx_q, idx_d;
  logic              take;
  logic              last;

  assign valid_o = (cnt_q != 3'd0);
  assign last    = ({1'b0, idx_q} == (cnt_q - 3'd1));
  assign take    = valid_o && ready_i;
  assign free_o  = !valid_o || (take && last);
  assign res_o   = r_q[idx_q];
  assign last_o  = last;

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (load_i) begin
      cnt_d = bundle_i.n;
      idx_d = 2'd0;
    end else if (take) begin
      if (last) begin
        cnt_d = 3'd0;
        idx_d = 2'd0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
      idx_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      r_q <= bundle_i.r;
    end
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'd4)
    else $error("result count above four");
  a_idx_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ({1'b0, idx_q} < cnt_q))
    else $error("drain index past count");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni) load_i |-> free_o)
    else $error("load while results pending");
  a_load_show: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && (bundle_i.n != 3'd0)) |=> (valid_o && (idx_q == 2'd0)))
    else $error("loaded results not shown");

endmodule
`default_nettype wire
